### sv/sequential_list_engine_core_assert.svh
// Assertion macros for the list engine RTL.
`ifndef SEQUENTIAL_LIST_ENGINE_CORE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SLE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("list engine check failed");
`define SLE_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("list engine reset check failed");
`else
`define SLE_ASSERT(lbl, prop)
`define SLE_ASSERT_RST(lbl, prop)
`endif
`endif

### sv/sle_pkg.sv
// Types and constants of the list engine.
package sle_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 5;
    localparam int STAT_W   = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] element;
        logic                     found;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
    } out_t;

    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         fill;
    } cell_ctrl_t;

endpackage

### sv/sle_cell.sv
// One list cell: holds one element, shifts with its neighbors, compares and selects.
module sle_cell (
    input  logic                             aclk,
    input  sle_pkg::cell_ctrl_t              ctrl,
    input  logic [sle_pkg::IDX_W-1:0]        cell_idx,
    input  logic signed [sle_pkg::DATA_W-1:0] left_data,
    input  logic signed [sle_pkg::DATA_W-1:0] right_data,
    output logic signed [sle_pkg::DATA_W-1:0] data,
    output logic signed [sle_pkg::DATA_W-1:0] hit_data,
    output logic                             match
);
    import sle_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     at_idx;
    logic                     above_idx;

    assign at_idx    = (cell_idx == ctrl.idx);
    assign above_idx = (cell_idx > ctrl.idx);

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            if (at_idx) begin
                data_next = ctrl.value;
            end else if (above_idx) begin
                data_next = left_data;
            end
        end else if (ctrl.del) begin
            if (at_idx || above_idx) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign hit_data = at_idx ? data_reg : '0;
    assign match    = (CNT_W'(cell_idx) < ctrl.fill) && (data_reg == ctrl.value);

endmodule

### sv/sle_out_skid.sv
// Result output register with a skid stage.
module sle_out_skid (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  sle_pkg::out_t in_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sle_pkg::out_t m_data
);
    import sle_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    out_t out_data_reg;
    out_t skid_data_reg;
    logic load_out;

    assign in_ready = !skid_valid_reg;
    assign load_out = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && in_ready) begin
            skid_data_reg <= in_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

### sv/sequential_list_engine_core.sv
// Top level of the list engine: cell chain, fill count, command decode.
//
//   port group   dir   role
//   s_*          in    command transfer (cmd, position, value)
//   m_*          out   result transfer (status, element, found, count, is_empty)
//
// One command per cycle while s_ready is high: the whole chain shifts, compares
// and selects in the cycle of the transfer; the result reaches m_* from a register.
// Two results may wait (output register and skid stage); s_ready drops only
// while both are held by a stalled m_ready.
// Reset clears the fill count and the result stages; cell contents stay unset.
module sequential_list_engine_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sle_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sle_pkg::out_t m_data
);
    import sle_pkg::*;

`include "sequential_list_engine_core_assert.svh"

    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic                     accept;
    logic                     pos_zero;
    logic                     ins_ok;
    logic                     rd_ok;
    logic                     full;
    logic [POS_W-1:0]         pos_m1;
    logic signed [DATA_W-1:0] elem_sel;
    logic                     any_match;
    cell_ctrl_t               ctrl;
    out_t                     res;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic signed [DATA_W-1:0] cell_hit  [CAPACITY];
    logic [CAPACITY-1:0]      cell_match;

    assign accept   = s_valid && s_ready;
    assign pos_zero = (s_data.position == '0);
    assign ins_ok   = !pos_zero && ({1'b0, s_data.position} <= ({1'b0, fill_reg} + 1'b1));
    assign rd_ok    = !pos_zero && (s_data.position <= fill_reg);
    assign full     = (fill_reg >= CNT_W'(CAPACITY));
    assign pos_m1   = s_data.position - 1'b1;

    always_comb begin
        ctrl.ins   = accept && (s_data.cmd == CMD_INSERT) && ins_ok && !full;
        ctrl.del   = accept && (s_data.cmd == CMD_DELETE) && rd_ok;
        ctrl.idx   = pos_m1[IDX_W-1:0];
        ctrl.value = s_data.value;
        ctrl.fill  = fill_reg;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic signed [DATA_W-1:0] left_d;
            logic signed [DATA_W-1:0] right_d;
            if (i == 0) begin : g_first
                assign left_d = cell_data[i];
            end else begin : g_mid_l
                assign left_d = cell_data[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign right_d = cell_data[i];
            end else begin : g_mid_r
                assign right_d = cell_data[i+1];
            end
            sle_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .cell_idx   (IDX_W'(i)),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[i]),
                .hit_data   (cell_hit[i]),
                .match      (cell_match[i])
            );
        end
    endgenerate

    always_comb begin
        elem_sel = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            elem_sel = elem_sel | cell_hit[k];
        end
    end

    assign any_match = |cell_match;

    always_comb begin
        fill_next    = fill_reg;
        res.status   = ST_OK;
        res.element  = '0;
        res.found    = 1'b0;
        unique case (s_data.cmd)
            CMD_INSERT: begin
                if (!ins_ok) begin
                    res.status = ST_RANGE;
                end else if (full) begin
                    res.status = ST_FULL;
                end else begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            CMD_DELETE: begin
                if (!rd_ok) begin
                    res.status = ST_RANGE;
                end else begin
                    res.element = elem_sel;
                    fill_next   = fill_reg - 1'b1;
                end
            end
            CMD_GET: begin
                if (!rd_ok) begin
                    res.status = ST_RANGE;
                end else begin
                    res.element = elem_sel;
                end
            end
            CMD_LOCATE: begin
                res.found = any_match;
            end
            CMD_CLEAR: begin
                fill_next = '0;
            end
            default: begin
            end
        endcase
        res.count    = fill_next;
        res.is_empty = (fill_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
        end
    end

    sle_out_skid u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    `SLE_ASSERT(a_fill_bound, fill_reg <= CNT_W'(CAPACITY))
    `SLE_ASSERT(a_insert_grows, ctrl.ins |=> fill_reg == $past(fill_reg) + 1'b1)
    `SLE_ASSERT(a_clear_empties, accept && (s_data.cmd == CMD_CLEAR) |=> fill_reg == '0)
    `SLE_ASSERT(a_fill_holds, !accept |=> $stable(fill_reg))
    `SLE_ASSERT_RST(a_reset_state, !aresetn |=> (fill_reg == '0) && !m_valid)

endmodule
